[rtl/core/ecsm_pkg.sv]
// Shared constants, codes and command/status types of the elliptic-curve scalar multiplier.
package ecsm_pkg;

    localparam int FIELD_BITS  = 16;
    localparam int SCALAR_BITS = 16;
    localparam int STEP_CNT_W  = $clog2(FIELD_BITS);
    localparam int BIT_CNT_W   = $clog2(SCALAR_BITS + 1);
    localparam int CFG_IDX_W   = 1;
    localparam int RF_DEPTH    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CURVE_A     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_PRIME = 1'b1;

    localparam logic [FIELD_BITS-1:0] CURVE_A_RESET     = 16'd1;
    localparam logic [FIELD_BITS-1:0] FIELD_PRIME_RESET = 16'd11;

    // Datapath operations.
    typedef enum logic [2:0] {
        OP_MOV,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_RED,
        OP_TEST
    } op_t;

    // Source of the first operand.
    typedef enum logic [2:0] {
        SRC_RF,
        SRC_BX_IN,
        SRC_BY_IN,
        SRC_A_CFG,
        SRC_ZERO,
        SRC_ONE,
        SRC_THREE,
        SRC_M
    } src_t;

    // Working register file entries.
    typedef enum logic [3:0] {
        R_X,
        R_Y,
        R_BX,
        R_BY,
        R_A,
        R_NUM,
        R_DEN,
        R_R0,
        R_R1,
        R_T0,
        R_T1,
        R_Q,
        R_TMP,
        R_LAM,
        R_NX,
        R_SPARE
    } rsel_t;

    typedef struct packed {
        logic  valid;
        op_t   op;
        src_t  src;
        rsel_t s1;
        rsel_t s2;
        rsel_t dst;
        logic  load;
        logic  shift_k;
        logic  publish;
        logic  inf;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic eq;
        logic zero;
        logic one;
        logic kbit;
        logic m_small;
        logic out_free;
    } stat_t;

endpackage

[rtl/core/ec_point_scalar_multiply_top.sv]
// Top level of the elliptic-curve scalar multiplier: controller and datapath.
//
//   channel  direction  handshake             payload
//   input    in         in_valid / in_stall   base_x, base_y, scalar
//   result   out        out_valid / out_stall result_x, result_y, at_infinity
//   config   in         cfg_write_en          cfg_index, cfg_data
//
// For a 16-bit scalar each word runs up to 32 point operations. Each one on two
// finite points that does not give infinity performs an extended Euclidean
// inversion (up to about 24 quotient steps) plus bit-serial modular multiplies,
// all through the one shared arithmetic unit.
// Reset is asynchronous and active low; no clearing pass is needed.
// The input stalls while a word is being computed. A finished word waits in the
// output register while the next input word is accepted and computed; the
// controller holds only when a new result would overwrite a waiting one.
module ec_point_scalar_multiply_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [ecsm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ecsm_pkg::FIELD_BITS-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ecsm_pkg::FIELD_BITS-1:0]     base_x,
    input  logic [ecsm_pkg::FIELD_BITS-1:0]     base_y,
    input  logic [ecsm_pkg::SCALAR_BITS-1:0]    scalar,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ecsm_pkg::FIELD_BITS-1:0]     result_x,
    output logic [ecsm_pkg::FIELD_BITS-1:0]     result_y,
    output logic                                at_infinity
);

    // Commands flow from the controller into the datapath; status flows back.
    ecsm_pkg::cmd_t  cmd;
    ecsm_pkg::stat_t st;

    // The controller walks the scalar from its top bit down, doubling and
    // conditionally adding, and keeps the point-at-infinity flag itself.
    ecsm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // The datapath holds the configuration, the working registers, the shared
    // modular add/subtract/multiply/divide unit and the result register.
    ecsm_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .base_x       (base_x),
        .base_y       (base_y),
        .scalar       (scalar),
        .cmd          (cmd),
        .st           (st),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_x     (result_x),
        .result_y     (result_y),
        .at_infinity  (at_infinity)
    );

endmodule

[rtl/core/ecsm_datapath.sv]
// Datapath: configuration, register file, modular arithmetic unit and output register.
module ecsm_datapath
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write_en,
    input  logic [ecsm_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [ecsm_pkg::FIELD_BITS-1:0]         cfg_data,
    input  logic [ecsm_pkg::FIELD_BITS-1:0]         base_x,
    input  logic [ecsm_pkg::FIELD_BITS-1:0]         base_y,
    input  logic [ecsm_pkg::SCALAR_BITS-1:0]        scalar,
    input  ecsm_pkg::cmd_t                          cmd,
    output ecsm_pkg::stat_t                         st,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [ecsm_pkg::FIELD_BITS-1:0]         result_x,
    output logic [ecsm_pkg::FIELD_BITS-1:0]         result_y,
    output logic                                    at_infinity
);

    localparam int W = ecsm_pkg::FIELD_BITS;

    typedef enum logic [1:0] {
        DP_IDLE,
        DP_RUN,
        DP_WRQ
    } phase_t;

    function automatic logic [W-1:0] md_add(input logic [W-1:0] u, input logic [W-1:0] v,
                                            input logic [W-1:0] m);
        logic [W:0] s;
        logic [W:0] d;
        s = {1'b0, u} + {1'b0, v};
        d = s - {1'b0, m};
        return (s >= {1'b0, m}) ? d[W-1:0] : s[W-1:0];
    endfunction

    function automatic logic [W-1:0] md_sub(input logic [W-1:0] u, input logic [W-1:0] v,
                                            input logic [W-1:0] m);
        return (u >= v) ? (u - v) : (u + (m - v));
    endfunction

    logic [W-1:0] curve_a_reg;
    logic [W-1:0] field_prime_reg;
    logic [W-1:0] bx_in_reg;
    logic [W-1:0] by_in_reg;
    logic [ecsm_pkg::SCALAR_BITS-1:0] k_reg;

    logic [W-1:0] mem [ecsm_pkg::RF_DEPTH];
    logic [W-1:0] rd_a_reg;
    logic [W-1:0] rd_b_reg;

    phase_t                            phase_reg, phase_next;
    ecsm_pkg::op_t                     op_reg;
    ecsm_pkg::src_t                    src_reg;
    ecsm_pkg::rsel_t                   dst_reg;
    logic [ecsm_pkg::STEP_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [W-1:0]                      acc_reg, acc_next;
    logic [W-1:0]                      q_reg, q_next;
    logic                              eq_reg, zero_reg, one_reg;
    logic                              flags_we;

    logic [W-1:0] res_x_reg, res_y_reg;
    logic         res_inf_reg;
    logic         out_valid_reg;

    logic                  wr_en;
    ecsm_pkg::rsel_t       wr_addr;
    logic [W-1:0]          wr_data;
    logic                  done;

    logic [W-1:0] op_a;
    logic [W-1:0] three_mod;
    logic [W-1:0] divisor;
    logic [ecsm_pkg::STEP_CNT_W-1:0] bit_idx;
    logic         cur_bit;
    logic [W-1:0] dbl_acc;
    logic [W-1:0] mul_step;
    logic [W:0]   div_shift;
    logic [W:0]   div_diff;
    logic         div_take;
    logic [W-1:0] div_step;
    logic         last_step;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_a_reg     <= ecsm_pkg::CURVE_A_RESET;
            field_prime_reg <= ecsm_pkg::FIELD_PRIME_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                ecsm_pkg::CFG_CURVE_A:     curve_a_reg     <= cfg_data;
                ecsm_pkg::CFG_FIELD_PRIME: field_prime_reg <= cfg_data;
                default:                   curve_a_reg     <= curve_a_reg;
            endcase
        end
    end

    // Captured input word and scalar shifter.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bx_in_reg <= base_x;
            by_in_reg <= base_y;
            k_reg     <= scalar;
        end
        else if (cmd.shift_k)
        begin
            k_reg <= {k_reg[ecsm_pkg::SCALAR_BITS-2:0], 1'b0};
        end
    end

    // Register file with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.valid)
        begin
            rd_a_reg <= mem[cmd.s1];
            rd_b_reg <= mem[cmd.s2];
        end
    end

    always_comb
    begin
        if (field_prime_reg == 16'd2)
        begin
            three_mod = 16'd1;
        end
        else if (field_prime_reg == 16'd3)
        begin
            three_mod = 16'd0;
        end
        else
        begin
            three_mod = 16'd3;
        end
    end

    always_comb
    begin
        case (src_reg)
            ecsm_pkg::SRC_RF:    op_a = rd_a_reg;
            ecsm_pkg::SRC_BX_IN: op_a = bx_in_reg;
            ecsm_pkg::SRC_BY_IN: op_a = by_in_reg;
            ecsm_pkg::SRC_A_CFG: op_a = curve_a_reg;
            ecsm_pkg::SRC_ZERO:  op_a = '0;
            ecsm_pkg::SRC_ONE:   op_a = W'(1);
            ecsm_pkg::SRC_THREE: op_a = three_mod;
            ecsm_pkg::SRC_M:     op_a = field_prime_reg;
            default:             op_a = '0;
        endcase
    end

    // One bit of a multiply or a divide per cycle, most significant bit first.
    assign bit_idx   = ecsm_pkg::STEP_CNT_W'(W - 1) - cnt_reg;
    assign last_step = (cnt_reg == ecsm_pkg::STEP_CNT_W'(W - 1));
    assign divisor   = (op_reg == ecsm_pkg::OP_RED) ? field_prime_reg : rd_b_reg;
    assign dbl_acc   = md_add(acc_reg, acc_reg, field_prime_reg);

    always_comb
    begin
        if (op_reg == ecsm_pkg::OP_MUL)
        begin
            cur_bit = rd_b_reg[bit_idx];
        end
        else
        begin
            cur_bit = op_a[bit_idx];
        end
    end

    assign mul_step  = cur_bit ? md_add(dbl_acc, op_a, field_prime_reg) : dbl_acc;
    assign div_shift = {acc_reg, cur_bit};
    assign div_diff  = div_shift - {1'b0, divisor};
    assign div_take  = (div_shift >= {1'b0, divisor});
    assign div_step  = div_take ? div_diff[W-1:0] : div_shift[W-1:0];

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        q_next     = q_reg;
        wr_en      = 1'b0;
        wr_addr    = dst_reg;
        wr_data    = op_a;
        flags_we   = 1'b0;
        done       = 1'b0;
        case (phase_reg)
            DP_IDLE:
            begin
                if (cmd.valid)
                begin
                    phase_next = DP_RUN;
                    cnt_next   = '0;
                    acc_next   = '0;
                    q_next     = '0;
                end
            end
            DP_RUN:
            begin
                case (op_reg)
                    ecsm_pkg::OP_MOV:
                    begin
                        wr_en      = 1'b1;
                        done       = 1'b1;
                        phase_next = DP_IDLE;
                    end
                    ecsm_pkg::OP_ADD:
                    begin
                        wr_en      = 1'b1;
                        wr_data    = md_add(op_a, rd_b_reg, field_prime_reg);
                        done       = 1'b1;
                        phase_next = DP_IDLE;
                    end
                    ecsm_pkg::OP_SUB:
                    begin
                        wr_en      = 1'b1;
                        wr_data    = md_sub(op_a, rd_b_reg, field_prime_reg);
                        done       = 1'b1;
                        phase_next = DP_IDLE;
                    end
                    ecsm_pkg::OP_TEST:
                    begin
                        flags_we   = 1'b1;
                        done       = 1'b1;
                        phase_next = DP_IDLE;
                    end
                    ecsm_pkg::OP_MUL:
                    begin
                        acc_next = mul_step;
                        cnt_next = cnt_reg + 1'b1;
                        if (last_step)
                        begin
                            wr_en      = 1'b1;
                            wr_data    = mul_step;
                            done       = 1'b1;
                            phase_next = DP_IDLE;
                        end
                    end
                    ecsm_pkg::OP_RED:
                    begin
                        acc_next = div_step;
                        cnt_next = cnt_reg + 1'b1;
                        if (last_step)
                        begin
                            wr_en      = 1'b1;
                            wr_data    = div_step;
                            done       = 1'b1;
                            phase_next = DP_IDLE;
                        end
                    end
                    ecsm_pkg::OP_DIV:
                    begin
                        acc_next = div_step;
                        q_next   = {q_reg[W-2:0], div_take};
                        cnt_next = cnt_reg + 1'b1;
                        if (last_step)
                        begin
                            wr_en      = 1'b1;
                            wr_data    = div_step;
                            phase_next = DP_WRQ;
                        end
                    end
                    default:
                    begin
                        phase_next = DP_IDLE;
                    end
                endcase
            end
            DP_WRQ:
            begin
                wr_en      = 1'b1;
                wr_addr    = ecsm_pkg::R_Q;
                wr_data    = q_reg;
                done       = 1'b1;
                phase_next = DP_IDLE;
            end
            default:
            begin
                phase_next = DP_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= DP_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        q_reg   <= q_next;
        if (cmd.valid)
        begin
            op_reg  <= cmd.op;
            src_reg <= cmd.src;
            dst_reg <= cmd.dst;
        end
        if (flags_we)
        begin
            eq_reg   <= (op_a == rd_b_reg);
            zero_reg <= (op_a == '0);
            one_reg  <= (op_a == W'(1));
        end
    end

    // Output register: a finished word waits here while the next item runs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            res_x_reg   <= cmd.inf ? '0 : rd_a_reg;
            res_y_reg   <= cmd.inf ? '0 : rd_b_reg;
            res_inf_reg <= cmd.inf;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_x    = res_x_reg;
    assign result_y    = res_y_reg;
    assign at_infinity = res_inf_reg;

    assign st.done     = done;
    assign st.eq       = eq_reg;
    assign st.zero     = zero_reg;
    assign st.one      = one_reg;
    assign st.kbit     = k_reg[ecsm_pkg::SCALAR_BITS-1];
    assign st.m_small  = (field_prime_reg < W'(2));
    assign st.out_free = !out_valid_reg || !out_stall;

    a_cmd_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid |-> phase_reg == DP_IDLE)
        else $error("command issued while the arithmetic unit is busy");

    a_multi_not_early: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == DP_RUN && !last_step &&
         (op_reg == ecsm_pkg::OP_MUL || op_reg == ecsm_pkg::OP_DIV ||
          op_reg == ecsm_pkg::OP_RED)) |-> !done)
        else $error("multi-cycle operation finished early");

    a_publish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> out_valid_reg)
        else $error("published result not presented");

    a_publish_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!out_valid_reg || !out_stall))
        else $error("result published over a word still waiting");

endmodule

[rtl/core/ecsm_ctrl.sv]
// Controller: sequences double-and-add, point formulas and Euclidean inversion.
module ecsm_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  ecsm_pkg::stat_t st,
    output ecsm_pkg::cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE, S_START, S_RA, S_RX, S_RY, S_LOOP, S_PADD, S_CPYX, S_CPYY, S_NOTINF,
        S_TX, S_TXD, S_TY, S_TYD, S_DEN2, S_TDEN, S_TDEND, S_XX, S_C3, S_N3, S_NA,
        S_NUMS, S_DENS, S_INV0, S_INV1, S_INV2, S_INV3, S_ETST, S_ETSTD, S_EDIV,
        S_EM0, S_EM1, S_EQR, S_EQM, S_ESB, S_ET0, S_ET1, S_GTST, S_GTSTD, S_GZ,
        S_LAM, S_L2, S_L3, S_L4, S_L5, S_L6, S_L7, S_L8, S_SETINF, S_AFTER,
        S_NEXT, S_OUT, S_FIN, S_WAIT
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic   inf_reg, inf_next;
    logic   dbl_reg, dbl_next;
    logic [ecsm_pkg::BIT_CNT_W-1:0] bits_reg, bits_next;

    ecsm_pkg::rsel_t p2x;
    ecsm_pkg::rsel_t p2y;
    logic            accept;

    function automatic ecsm_pkg::cmd_t mk(input ecsm_pkg::op_t op, input ecsm_pkg::src_t src,
                                          input ecsm_pkg::rsel_t s1, input ecsm_pkg::rsel_t s2,
                                          input ecsm_pkg::rsel_t dst);
        ecsm_pkg::cmd_t c;
        c         = '0;
        c.valid   = 1'b1;
        c.op      = op;
        c.src     = src;
        c.s1      = s1;
        c.s2      = s2;
        c.dst     = dst;
        return c;
    endfunction

    assign p2x      = dbl_reg ? ecsm_pkg::R_X : ecsm_pkg::R_BX;
    assign p2y      = dbl_reg ? ecsm_pkg::R_Y : ecsm_pkg::R_BY;
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        inf_next   = inf_reg;
        dbl_next   = dbl_reg;
        bits_next  = bits_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    inf_next   = 1'b1;
                    bits_next  = '0;
                    state_next = S_START;
                end
            end
            S_START:   state_next = st.m_small ? S_FIN : S_RA;
            S_RA:
            begin
                cmd = mk(ecsm_pkg::OP_RED, ecsm_pkg::SRC_A_CFG, ecsm_pkg::R_A,
                         ecsm_pkg::R_A, ecsm_pkg::R_A);
                ret_next = S_RX;
            end
            S_RX:
            begin
                cmd = mk(ecsm_pkg::OP_RED, ecsm_pkg::SRC_BX_IN, ecsm_pkg::R_BX,
                         ecsm_pkg::R_BX, ecsm_pkg::R_BX);
                ret_next = S_RY;
            end
            S_RY:
            begin
                cmd = mk(ecsm_pkg::OP_RED, ecsm_pkg::SRC_BY_IN, ecsm_pkg::R_BY,
                         ecsm_pkg::R_BY, ecsm_pkg::R_BY);
                ret_next = S_LOOP;
            end
            S_LOOP:
            begin
                if (bits_reg == ecsm_pkg::BIT_CNT_W'(ecsm_pkg::SCALAR_BITS))
                begin
                    state_next = inf_reg ? S_FIN : S_OUT;
                end
                else
                begin
                    dbl_next   = 1'b1;
                    state_next = S_PADD;
                end
            end
            S_PADD:
            begin
                if (inf_reg)
                begin
                    state_next = dbl_reg ? S_AFTER : S_CPYX;
                end
                else
                begin
                    state_next = S_TX;
                end
            end
            S_CPYX:
            begin
                cmd = mk(ecsm_pkg::OP_MOV, ecsm_pkg::SRC_RF, ecsm_pkg::R_BX,
                         ecsm_pkg::R_BX, ecsm_pkg::R_X);
                ret_next = S_CPYY;
            end
            S_CPYY:
            begin
                cmd = mk(ecsm_pkg::OP_MOV, ecsm_pkg::SRC_RF, ecsm_pkg::R_BY,
                         ecsm_pkg::R_BY, ecsm_pkg::R_Y);
                ret_next = S_NOTINF;
            end
            S_NOTINF:
            begin
                inf_next   = 1'b0;
                state_next = S_AFTER;
            end
            S_TX:
            begin
                cmd = mk(ecsm_pkg::OP_TEST, ecsm_pkg::SRC_RF, ecsm_pkg::R_X, p2x, ecsm_pkg::R_X);
                ret_next = S_TXD;
            end
            S_TXD:     state_next = st.eq ? S_TY : S_NUMS;
            S_TY:
            begin
                cmd = mk(ecsm_pkg::OP_TEST, ecsm_pkg::SRC_RF, ecsm_pkg::R_Y, p2y, ecsm_pkg::R_Y);
                ret_next = S_TYD;
            end
            S_TYD:     state_next = st.eq ? S_DEN2 : S_SETINF;
            S_DEN2:
            begin
                cmd = mk(ecsm_pkg::OP_ADD, ecsm_pkg::SRC_RF, ecsm_pkg::R_Y,
                         ecsm_pkg::R_Y, ecsm_pkg::R_DEN);
                ret_next = S_TDEN;
            end
            S_TDEN:
            begin
                cmd = mk(ecsm_pkg::OP_TEST, ecsm_pkg::SRC_RF, ecsm_pkg::R_DEN,
                         ecsm_pkg::R_DEN, ecsm_pkg::R_DEN);
                ret_next = S_TDEND;
            end
            S_TDEND:   state_next = st.zero ? S_SETINF : S_XX;
            S_XX:
            begin
                cmd = mk(ecsm_pkg::OP_MUL, ecsm_pkg::SRC_RF, ecsm_pkg::R_X,
                         ecsm_pkg::R_X, ecsm_pkg::R_NUM);
                ret_next = S_C3;
            end
            S_C3:
            begin
                cmd = mk(ecsm_pkg::OP_MOV, ecsm_pkg::SRC_THREE, ecsm_pkg::R_TMP,
                         ecsm_pkg::R_TMP, ecsm_pkg::R_TMP);
                ret_next = S_N3;
            end
            S_N3:
            begin
                cmd = mk(ecsm_pkg::OP_MUL, ecsm_pkg::SRC_RF, ecsm_pkg::R_NUM,
                         ecsm_pkg::R_TMP, ecsm_pkg::R_NUM);
                ret_next = S_NA;
            end
            S_NA:
            begin
                cmd = mk(ecsm_pkg::OP_ADD, ecsm_pkg::SRC_RF, ecsm_pkg::R_NUM,
                         ecsm_pkg::R_A, ecsm_pkg::R_NUM);
                ret_next = S_INV0;
            end
            S_NUMS:
            begin
                cmd = mk(ecsm_pkg::OP_SUB, ecsm_pkg::SRC_RF, p2y, ecsm_pkg::R_Y, ecsm_pkg::R_NUM);
                ret_next = S_DENS;
            end
            S_DENS:
            begin
                cmd = mk(ecsm_pkg::OP_SUB, ecsm_pkg::SRC_RF, p2x, ecsm_pkg::R_X, ecsm_pkg::R_DEN);
                ret_next = S_INV0;
            end
            S_INV0:
            begin
                cmd = mk(ecsm_pkg::OP_MOV, ecsm_pkg::SRC_M, ecsm_pkg::R_R0,
                         ecsm_pkg::R_R0, ecsm_pkg::R_R0);
                ret_next = S_INV1;
            end
            S_INV1:
            begin
                cmd = mk(ecsm_pkg::OP_MOV, ecsm_pkg::SRC_RF, ecsm_pkg::R_DEN,
                         ecsm_pkg::R_DEN, ecsm_pkg::R_R1);
                ret_next = S_INV2;
            end
            S_INV2:
            begin
                cmd = mk(ecsm_pkg::OP_MOV, ecsm_pkg::SRC_ZERO, ecsm_pkg::R_T0,
                         ecsm_pkg::R_T0, ecsm_pkg::R_T0);
                ret_next = S_INV3;
            end
            S_INV3:
            begin
                cmd = mk(ecsm_pkg::OP_MOV, ecsm_pkg::SRC_ONE, ecsm_pkg::R_T1,
                         ecsm_pkg::R_T1, ecsm_pkg::R_T1);
                ret_next = S_ETST;
            end
            S_ETST:
            begin
                cmd = mk(ecsm_pkg::OP_TEST, ecsm_pkg::SRC_RF, ecsm_pkg::R_R1,
                         ecsm_pkg::R_R1, ecsm_pkg::R_R1);
                ret_next = S_ETSTD;
            end
            S_ETSTD:   state_next = st.zero ? S_GTST : S_EDIV;
            S_EDIV:
            begin
                cmd = mk(ecsm_pkg::OP_DIV, ecsm_pkg::SRC_RF, ecsm_pkg::R_R0,
                         ecsm_pkg::R_R1, ecsm_pkg::R_TMP);
                ret_next = S_EM0;
            end
            S_EM0:
            begin
                cmd = mk(ecsm_pkg::OP_MOV, ecsm_pkg::SRC_RF, ecsm_pkg::R_R1,
                         ecsm_pkg::R_R1, ecsm_pkg::R_R0);
                ret_next = S_EM1;
            end
            S_EM1:
            begin
                cmd = mk(ecsm_pkg::OP_MOV, ecsm_pkg::SRC_RF, ecsm_pkg::R_TMP,
                         ecsm_pkg::R_TMP, ecsm_pkg::R_R1);
                ret_next = S_EQR;
            end
            S_EQR:
            begin
                cmd = mk(ecsm_pkg::OP_RED, ecsm_pkg::SRC_RF, ecsm_pkg::R_Q,
                         ecsm_pkg::R_Q, ecsm_pkg::R_Q);
                ret_next = S_EQM;
            end
            S_EQM:
            begin
                cmd = mk(ecsm_pkg::OP_MUL, ecsm_pkg::SRC_RF, ecsm_pkg::R_Q,
                         ecsm_pkg::R_T1, ecsm_pkg::R_TMP);
                ret_next = S_ESB;
            end
            S_ESB:
            begin
                cmd = mk(ecsm_pkg::OP_SUB, ecsm_pkg::SRC_RF, ecsm_pkg::R_T0,
                         ecsm_pkg::R_TMP, ecsm_pkg::R_TMP);
                ret_next = S_ET0;
            end
            S_ET0:
            begin
                cmd = mk(ecsm_pkg::OP_MOV, ecsm_pkg::SRC_RF, ecsm_pkg::R_T1,
                         ecsm_pkg::R_T1, ecsm_pkg::R_T0);
                ret_next = S_ET1;
            end
            S_ET1:
            begin
                cmd = mk(ecsm_pkg::OP_MOV, ecsm_pkg::SRC_RF, ecsm_pkg::R_TMP,
                         ecsm_pkg::R_TMP, ecsm_pkg::R_T1);
                ret_next = S_ETST;
            end
            S_GTST:
            begin
                cmd = mk(ecsm_pkg::OP_TEST, ecsm_pkg::SRC_RF, ecsm_pkg::R_R0,
                         ecsm_pkg::R_R0, ecsm_pkg::R_R0);
                ret_next = S_GTSTD;
            end
            S_GTSTD:   state_next = st.one ? S_LAM : S_GZ;
            S_GZ:
            begin
                cmd = mk(ecsm_pkg::OP_MOV, ecsm_pkg::SRC_ZERO, ecsm_pkg::R_T0,
                         ecsm_pkg::R_T0, ecsm_pkg::R_T0);
                ret_next = S_LAM;
            end
            S_LAM:
            begin
                cmd = mk(ecsm_pkg::OP_MUL, ecsm_pkg::SRC_RF, ecsm_pkg::R_NUM,
                         ecsm_pkg::R_T0, ecsm_pkg::R_LAM);
                ret_next = S_L2;
            end
            S_L2:
            begin
                cmd = mk(ecsm_pkg::OP_MUL, ecsm_pkg::SRC_RF, ecsm_pkg::R_LAM,
                         ecsm_pkg::R_LAM, ecsm_pkg::R_TMP);
                ret_next = S_L3;
            end
            S_L3:
            begin
                cmd = mk(ecsm_pkg::OP_SUB, ecsm_pkg::SRC_RF, ecsm_pkg::R_TMP,
                         ecsm_pkg::R_X, ecsm_pkg::R_TMP);
                ret_next = S_L4;
            end
            S_L4:
            begin
                cmd = mk(ecsm_pkg::OP_SUB, ecsm_pkg::SRC_RF, ecsm_pkg::R_TMP, p2x, ecsm_pkg::R_NX);
                ret_next = S_L5;
            end
            S_L5:
            begin
                cmd = mk(ecsm_pkg::OP_SUB, ecsm_pkg::SRC_RF, ecsm_pkg::R_X,
                         ecsm_pkg::R_NX, ecsm_pkg::R_TMP);
                ret_next = S_L6;
            end
            S_L6:
            begin
                cmd = mk(ecsm_pkg::OP_MUL, ecsm_pkg::SRC_RF, ecsm_pkg::R_LAM,
                         ecsm_pkg::R_TMP, ecsm_pkg::R_TMP);
                ret_next = S_L7;
            end
            S_L7:
            begin
                cmd = mk(ecsm_pkg::OP_SUB, ecsm_pkg::SRC_RF, ecsm_pkg::R_TMP,
                         ecsm_pkg::R_Y, ecsm_pkg::R_Y);
                ret_next = S_L8;
            end
            S_L8:
            begin
                cmd = mk(ecsm_pkg::OP_MOV, ecsm_pkg::SRC_RF, ecsm_pkg::R_NX,
                         ecsm_pkg::R_NX, ecsm_pkg::R_X);
                ret_next = S_NOTINF;
            end
            S_SETINF:
            begin
                inf_next   = 1'b1;
                state_next = S_AFTER;
            end
            S_AFTER:
            begin
                if (dbl_reg)
                begin
                    dbl_next   = 1'b0;
                    state_next = st.kbit ? S_PADD : S_NEXT;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                cmd.shift_k = 1'b1;
                bits_next   = bits_reg + 1'b1;
                state_next  = S_LOOP;
            end
            S_OUT:
            begin
                cmd = mk(ecsm_pkg::OP_TEST, ecsm_pkg::SRC_RF, ecsm_pkg::R_X,
                         ecsm_pkg::R_Y, ecsm_pkg::R_X);
                ret_next = S_FIN;
            end
            S_FIN:
            begin
                if (st.out_free)
                begin
                    cmd.publish = 1'b1;
                    cmd.inf     = inf_reg;
                    state_next  = S_IDLE;
                end
            end
            S_WAIT:
            begin
                if (st.done)
                begin
                    state_next = ret_reg;
                end
            end
            default:   state_next = S_IDLE;
        endcase
        if (cmd.valid)
        begin
            state_next = S_WAIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            inf_reg   <= 1'b1;
            dbl_reg   <= 1'b0;
            bits_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            inf_reg   <= inf_next;
            dbl_reg   <= dbl_next;
            bits_reg  <= bits_next;
        end
    end

    a_accept_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("input taken but controller did not start");

    a_wait_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT && st.done) |=> state_reg != S_WAIT)
        else $error("controller missed the completion of an operation");

    a_bits_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bits_reg <= ecsm_pkg::BIT_CNT_W'(ecsm_pkg::SCALAR_BITS))
        else $error("scalar bit counter ran past the scalar width");

endmodule

[bench/tb.sv]
// Self-checking bench for the elliptic-curve scalar multiplier top level.
`timescale 1ns / 100ps

module tb;

    // Cycles with no word moving on either channel before the run is abandoned.
    localparam int STALL_LIMIT = 400000;

    typedef struct {
        logic [ecsm_pkg::FIELD_BITS-1:0] x;
        logic [ecsm_pkg::FIELD_BITS-1:0] y;
        logic                            inf;
    } ec_point_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_write_en;
    logic [ecsm_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [ecsm_pkg::FIELD_BITS-1:0]  cfg_data;
    logic                             in_valid;
    logic                             in_stall;
    logic [ecsm_pkg::FIELD_BITS-1:0]  base_x;
    logic [ecsm_pkg::FIELD_BITS-1:0]  base_y;
    logic [ecsm_pkg::SCALAR_BITS-1:0] scalar;
    logic                             out_valid;
    logic                             out_stall;
    logic [ecsm_pkg::FIELD_BITS-1:0]  result_x;
    logic [ecsm_pkg::FIELD_BITS-1:0]  result_y;
    logic                             at_infinity;

    // The bench's own copy of the two configuration registers.
    logic [ecsm_pkg::FIELD_BITS-1:0] model_a;
    logic [ecsm_pkg::FIELD_BITS-1:0] model_p;

    // Products of k * P still owed by the block, oldest first.
    ec_point_t pending_products[$];

    int error_count;
    int idle_pct;
    int stall_pct;
    int quiet_cycles;

    ec_point_scalar_multiply_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .base_x       (base_x),
        .base_y       (base_y),
        .scalar       (scalar),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_x     (result_x),
        .result_y     (result_y),
        .at_infinity  (at_infinity)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Field arithmetic. All operands are below m and below 2^16, so the
    // plain 64-bit expressions give the exact residues.
    function automatic longint unsigned fmul(longint unsigned u, longint unsigned v,
                                             longint unsigned m);
        return (u * v) % m;
    endfunction

    function automatic longint unsigned fadd(longint unsigned u, longint unsigned v,
                                             longint unsigned m);
        return (u + v) % m;
    endfunction

    function automatic longint unsigned fsub(longint unsigned u, longint unsigned v,
                                             longint unsigned m);
        return (u + m - v) % m;
    endfunction

    // Extended Euclid. When the denominator shares a factor with a composite
    // modulus there is no inverse, and the block then uses zero.
    function automatic longint unsigned finv(longint unsigned v, longint unsigned m);
        longint unsigned r0, r1, t0, t1, q, tmp;
        r0 = m;
        r1 = v;
        t0 = 0;
        t1 = 1;
        while (r1 != 0)
        begin
            q   = r0 / r1;
            tmp = r0 - q * r1;
            r0  = r1;
            r1  = tmp;
            tmp = fsub(t0, fmul(q % m, t1, m), m);
            t0  = t1;
            t1  = tmp;
        end
        return (r0 == 1) ? t0 : 0;
    endfunction

    // Affine point addition with infinity as the identity; equal points double.
    function automatic ec_point_t point_add(ec_point_t p1, ec_point_t p2,
                                            longint unsigned a, longint unsigned m);
        ec_point_t       r;
        longint unsigned num, den, lam, nx;
        if (p1.inf)
            return p2;
        if (p2.inf)
            return p1;
        r = '{x: '0, y: '0, inf: 1'b1};
        if (p1.x == p2.x)
        begin
            // Opposite points, or a vertical tangent, give infinity.
            if (p1.y != p2.y)
                return r;
            den = fadd(p1.y, p1.y, m);
            if (den == 0)
                return r;
            num = fadd(fmul(3 % m, fmul(p1.x, p1.x, m), m), a, m);
        end
        else
        begin
            num = fsub(p2.y, p1.y, m);
            den = fsub(p2.x, p1.x, m);
        end
        lam  = fmul(num, finv(den, m), m);
        nx   = fsub(fsub(fmul(lam, lam, m), p1.x, m), p2.x, m);
        r.y  = ecsm_pkg::FIELD_BITS'(fsub(fmul(lam, fsub(p1.x, nx, m), m), p1.y, m));
        r.x  = ecsm_pkg::FIELD_BITS'(nx);
        r.inf = 1'b0;
        return r;
    endfunction

    // Left-to-right double-and-add over all scalar bits.
    function automatic ec_point_t scalar_product(logic [ecsm_pkg::FIELD_BITS-1:0] bx,
                                                 logic [ecsm_pkg::FIELD_BITS-1:0] by,
                                                 logic [ecsm_pkg::SCALAR_BITS-1:0] k);
        ec_point_t       acc, base;
        longint unsigned m, a;
        acc = '{x: '0, y: '0, inf: 1'b1};
        m = model_p;
        if (m >= 2)
        begin
            a    = model_a % m;
            base = '{x: ecsm_pkg::FIELD_BITS'(bx % m), y: ecsm_pkg::FIELD_BITS'(by % m),
                     inf: 1'b0};
            for (int i = ecsm_pkg::SCALAR_BITS - 1; i >= 0; i--)
            begin
                acc = point_add(acc, acc, a, m);
                if (k[i])
                    acc = point_add(acc, base, a, m);
            end
        end
        if (acc.inf)
        begin
            acc.x = '0;
            acc.y = '0;
        end
        return acc;
    endfunction

    // Result side: random stall, checking of every accepted word, and the
    // watchdog that ends a run in which nothing moves.
    always @(posedge clk)
    begin
        ec_point_t want;
        if (rst_n)
        begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else if (out_valid && !out_stall)
            begin
                if (pending_products.size() == 0)
                begin
                    $display("%0t: unexpected result word x=%0d y=%0d inf=%0b",
                             $time, result_x, result_y, at_infinity);
                    error_count++;
                end
                else
                begin
                    want = pending_products.pop_front();
                    if (result_x !== want.x)
                    begin
                        $display("%0t: result_x expected %0d actual %0d",
                                 $time, want.x, result_x);
                        error_count++;
                    end
                    if (result_y !== want.y)
                    begin
                        $display("%0t: result_y expected %0d actual %0d",
                                 $time, want.y, result_y);
                        error_count++;
                    end
                    if (at_infinity !== want.inf)
                    begin
                        $display("%0t: at_infinity expected %0b actual %0b",
                                 $time, want.inf, at_infinity);
                        error_count++;
                    end
                end
            end
        end
    end

    // Leaves the input idle on a random share of cycles, then offers one word,
    // holds it until the block takes it and records the product it must return.
    task automatic send_word(logic [ecsm_pkg::FIELD_BITS-1:0] x,
                             logic [ecsm_pkg::FIELD_BITS-1:0] y,
                             logic [ecsm_pkg::SCALAR_BITS-1:0] k);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        base_x   <= x;
        base_y   <= y;
        scalar   <= k;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_products.insert(pending_products.size(), scalar_product(x, y, k));
    endtask

    // Lets every owed result drain; registers may only change while idle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_products.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
    endtask

    task automatic write_curve(logic [ecsm_pkg::FIELD_BITS-1:0] a,
                               logic [ecsm_pkg::FIELD_BITS-1:0] p);
        wait_drained();
        cfg_write_en <= 1'b1;
        cfg_index    <= ecsm_pkg::CFG_CURVE_A;
        cfg_data     <= a;
        @(posedge clk);
        cfg_index    <= ecsm_pkg::CFG_FIELD_PRIME;
        cfg_data     <= p;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        model_a = a;
        model_p = p;
    endtask

    // Directed words on the reset curve (a = 1, p = 11) and a few others.
    task automatic test_directed();
        idle_pct  = 0;
        stall_pct = 0;
        send_word(16'd2, 16'd7, 16'd0);              // zero scalar
        send_word(16'd2, 16'd7, 16'd1);
        send_word(16'd2, 16'd7, 16'd2);
        send_word(16'd5, 16'd0, 16'd2);              // vertical tangent
        send_word(16'd5, 16'd0, 16'd3);
        send_word(16'hFFFF, 16'hFFFF, 16'hFFFF);     // coordinates above p
        send_word(16'd0, 16'd0, 16'h8000);
        send_word(16'd3, 16'd1, 16'h5555);
        send_word(16'd7, 16'd9, 16'hAAAA);
        // Scalars around a small group order reach opposite-point additions.
        for (int k = 3; k <= 14; k++)
            send_word(16'd2, 16'd7, k[ecsm_pkg::SCALAR_BITS-1:0]);
        // A modulus below two always yields infinity.
        write_curve(16'd3, 16'd0);
        send_word(16'd1, 16'd2, 16'd5);
        write_curve(16'd3, 16'd1);
        send_word(16'hFFFF, 16'd2, 16'hFFFF);
        // Composite modulus: denominators without inverse give slope zero.
        write_curve(16'd2, 16'd15);
        send_word(16'd3, 16'd5, 16'd7);
        send_word(16'd6, 16'd10, 16'hFFFF);
    endtask

    // Random words on the given curve. Most points are reduced field
    // elements; the rest are raw 16-bit values. Scalars are a mix of full
    // width and small values, which hit infinity often on small fields.
    task automatic test_random(int count, int idle, int stall,
                               logic [ecsm_pkg::FIELD_BITS-1:0] a,
                               logic [ecsm_pkg::FIELD_BITS-1:0] p);
        logic [ecsm_pkg::FIELD_BITS-1:0]  x, y;
        logic [ecsm_pkg::SCALAR_BITS-1:0] k;
        int                               m;
        write_curve(a, p);
        idle_pct  = idle;
        stall_pct = stall;
        m = (p < 2) ? 2 : int'(p);
        repeat (count)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                x = ecsm_pkg::FIELD_BITS'($urandom_range(0, m - 1));
                y = ecsm_pkg::FIELD_BITS'($urandom_range(0, m - 1));
            end
            else
            begin
                x = ecsm_pkg::FIELD_BITS'($urandom());
                y = ecsm_pkg::FIELD_BITS'($urandom());
            end
            if ($urandom_range(0, 2) == 0)
                k = ecsm_pkg::SCALAR_BITS'($urandom_range(0, 40));
            else
                k = ecsm_pkg::SCALAR_BITS'($urandom());
            send_word(x, y, k);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = ecsm_pkg::CFG_CURVE_A;
        cfg_data     = '0;
        in_valid     = 1'b0;
        base_x       = '0;
        base_y       = '0;
        scalar       = '0;
        out_stall    = 1'b0;
        error_count  = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        quiet_cycles = 0;
        model_a      = ecsm_pkg::CURVE_A_RESET;
        model_p      = ecsm_pkg::FIELD_PRIME_RESET;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        // Phases sweep both idling patterns and curves from tiny to the
        // largest 16-bit prime, with a at both of its extremes.
        test_random(60, 0, 0, 16'd0, 16'd5);
        test_random(60, 49, 0, 16'hFFFF, 16'd7);
        test_random(60, 0, 49, 16'd12345, 16'd65521);
        test_random(60, 35, 35, 16'd4, 16'd101);
        test_random(40, 35, 35, 16'd0, 16'd65521);
        test_random(20, 0, 0, 16'd9, 16'd4);

        wait_drained();
        repeat (100)
            @(posedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[sim.f]
rtl/core/ecsm_pkg.sv
rtl/core/ecsm_datapath.sv
rtl/core/ecsm_ctrl.sv
rtl/core/ec_point_scalar_multiply_top.sv
bench/tb.sv
